@@ sv/lifrk_pkg.sv @@
`default_nettype none

package lifrk_pkg;

    // Fixed-point format and datapath widths
    localparam int FRAC_BITS   = 16;
    localparam int DATA_W      = 32;
    localparam int GAIN_W      = 31;
    localparam int OPND_W      = DATA_W + 1;
    localparam int PROD_W      = 2 * OPND_W;
    localparam int CNT_W       = 16;
    localparam int DECAY_W     = 17;
    localparam int DECAY_SHIFT = 16;
    localparam int ADDR_W      = 5;
    localparam int APB_W       = 32;

    localparam logic [CNT_W-1:0]   REFRACT_TICKS = 16'd2;
    localparam logic [DECAY_W-1:0] DECAY_ONE     = 17'h1_0000;

    // Register map, index = byte address / 4
    typedef enum logic [2:0] {
        REG_LEAK_REV   = 3'd0,
        REG_SYN_REV    = 3'd1,
        REG_LEAK_GAIN  = 3'd2,
        REG_SYN_HALF   = 3'd3,
        REG_SYN_FULL   = 3'd4,
        REG_THR_BASE   = 3'd5,
        REG_THR_MAX    = 3'd6,
        REG_THR_DECAY  = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [DATA_W-1:0]  leak_reversal;
        logic [DATA_W-1:0]  syn_reversal;
        logic [GAIN_W-1:0]  leak_gain;
        logic [GAIN_W-1:0]  syn_gain_half;
        logic [GAIN_W-1:0]  syn_gain_full;
        logic [DATA_W-1:0]  thresh_base;
        logic [DATA_W-1:0]  thresh_max;
        logic [DECAY_W-1:0] thresh_decay;
    } cfg_t;

    // Operand pair fed to the shared multiplier
    typedef enum logic [2:0] {
        MUL_DRV_HALF = 3'd0,
        MUL_DRV_FULL = 3'd1,
        MUL_LEAK     = 3'd2,
        MUL_SYN      = 3'd3,
        MUL_THR      = 3'd4,
        MUL_RECIP    = 3'd5
    } mul_sel_t;

    // Update of the weighted slope sum
    typedef enum logic [1:0] {
        SUM_HOLD = 2'd0,
        SUM_LOAD = 2'd1,
        SUM_ADD2 = 2'd2,
        SUM_ADD1 = 2'd3
    } sum_op_t;

    typedef struct packed {
        logic     ld_in;
        mul_sel_t mul_sel;
        logic     syn_full;
        logic     ld_ch;
        logic     ld_cf;
        logic     ld_acc;
        logic     ld_d;
        logic     syn_zero;
        logic     ld_thr;
        logic     ld_vs;
        logic     vs_full;
        sum_op_t  sum_op;
        logic     ld_t;
        logic     ld_q;
        logic     ld_vnew;
        logic     commit;
    } dp_cmd_t;

endpackage

`default_nettype wire

@@ sv/lifrk_regs.sv @@
`default_nettype none

module lifrk_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lifrk_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [lifrk_pkg::APB_W-1:0]   pwdata,
    output logic      [lifrk_pkg::APB_W-1:0]   prdata,
    output logic                               pready,
    output lifrk_pkg::cfg_t                    cfg
);

    lifrk_pkg::cfg_t     cfg_reg;
    lifrk_pkg::cfg_t     cfg_next;
    lifrk_pkg::reg_idx_t idx;
    logic                wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign idx    = lifrk_pkg::reg_idx_t'(paddr[lifrk_pkg::ADDR_W-1:2]);
    assign cfg    = cfg_reg;

    // Write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                lifrk_pkg::REG_LEAK_REV:  cfg_next.leak_reversal = pwdata;
                lifrk_pkg::REG_SYN_REV:   cfg_next.syn_reversal  = pwdata;
                lifrk_pkg::REG_LEAK_GAIN:
                    cfg_next.leak_gain = pwdata[lifrk_pkg::GAIN_W-1:0];
                lifrk_pkg::REG_SYN_HALF:
                    cfg_next.syn_gain_half = pwdata[lifrk_pkg::GAIN_W-1:0];
                lifrk_pkg::REG_SYN_FULL:
                    cfg_next.syn_gain_full = pwdata[lifrk_pkg::GAIN_W-1:0];
                lifrk_pkg::REG_THR_BASE:  cfg_next.thresh_base   = pwdata;
                lifrk_pkg::REG_THR_MAX:   cfg_next.thresh_max    = pwdata;
                lifrk_pkg::REG_THR_DECAY:
                    cfg_next.thresh_decay = pwdata[lifrk_pkg::DECAY_W-1:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux, narrow registers zero-extended
    always_comb begin
        unique case (idx)
            lifrk_pkg::REG_LEAK_REV:  prdata = cfg_reg.leak_reversal;
            lifrk_pkg::REG_SYN_REV:   prdata = cfg_reg.syn_reversal;
            lifrk_pkg::REG_LEAK_GAIN: prdata = {1'b0, cfg_reg.leak_gain};
            lifrk_pkg::REG_SYN_HALF:  prdata = {1'b0, cfg_reg.syn_gain_half};
            lifrk_pkg::REG_SYN_FULL:  prdata = {1'b0, cfg_reg.syn_gain_full};
            lifrk_pkg::REG_THR_BASE:  prdata = cfg_reg.thresh_base;
            lifrk_pkg::REG_THR_MAX:   prdata = cfg_reg.thresh_max;
            lifrk_pkg::REG_THR_DECAY:
                prdata = {{(lifrk_pkg::APB_W-lifrk_pkg::DECAY_W){1'b0}},
                          cfg_reg.thresh_decay};
        endcase
    end

endmodule

`default_nettype wire

@@ sv/lifrk_ctrl.sv @@
`default_nettype none

module lifrk_ctrl (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output lifrk_pkg::dp_cmd_t cmd
);

    typedef enum logic [11:0] {
        ST_IDLE = 12'b0000_0000_0001,
        ST_CH   = 12'b0000_0000_0010,
        ST_CF   = 12'b0000_0000_0100,
        ST_LK   = 12'b0000_0000_1000,
        ST_SY   = 12'b0000_0001_0000,
        ST_TM   = 12'b0000_0010_0000,
        ST_NX   = 12'b0000_0100_0000,
        ST_TP   = 12'b0000_1000_0000,
        ST_DV   = 12'b0001_0000_0000,
        ST_QC   = 12'b0010_0000_0000,
        ST_FN   = 12'b0100_0000_0000,
        ST_OUT  = 12'b1000_0000_0000
    } state_t;

    localparam logic [1:0] FIRST_STAGE = 2'd0;
    localparam logic [1:0] THIRD_STAGE = 2'd2;
    localparam logic [1:0] LAST_STAGE  = 2'd3;

    state_t     state_reg, state_next;
    logic [1:0] stage_reg, stage_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;

    // Sequence one item through the four slope stages and the final update
    always_comb begin
        state_next = state_reg;
        stage_next = stage_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.ld_in  = 1'b1;
                    stage_next = FIRST_STAGE;
                    state_next = ST_CH;
                end
            end
            ST_CH: begin
                cmd.mul_sel = lifrk_pkg::MUL_DRV_HALF;
                state_next  = ST_CF;
            end
            ST_CF: begin
                cmd.ld_ch   = 1'b1;
                cmd.mul_sel = lifrk_pkg::MUL_DRV_FULL;
                state_next  = ST_LK;
            end
            ST_LK: begin
                cmd.ld_cf   = (stage_reg == FIRST_STAGE);
                cmd.mul_sel = lifrk_pkg::MUL_LEAK;
                state_next  = ST_SY;
            end
            ST_SY: begin
                // first stage has no synaptic term: use the slot for the threshold
                cmd.ld_acc   = 1'b1;
                cmd.mul_sel  = (stage_reg == FIRST_STAGE) ? lifrk_pkg::MUL_THR
                                                          : lifrk_pkg::MUL_SYN;
                cmd.syn_full = (stage_reg == LAST_STAGE);
                state_next   = ST_TM;
            end
            ST_TM: begin
                cmd.ld_d     = 1'b1;
                cmd.syn_zero = (stage_reg == FIRST_STAGE);
                cmd.ld_thr   = (stage_reg == FIRST_STAGE);
                state_next   = ST_NX;
            end
            ST_NX: begin
                cmd.ld_vs   = (stage_reg != LAST_STAGE);
                cmd.vs_full = (stage_reg == THIRD_STAGE);
                if (stage_reg == FIRST_STAGE) begin
                    cmd.sum_op = lifrk_pkg::SUM_LOAD;
                end else if (stage_reg == LAST_STAGE) begin
                    cmd.sum_op = lifrk_pkg::SUM_ADD1;
                end else begin
                    cmd.sum_op = lifrk_pkg::SUM_ADD2;
                end
                if (stage_reg == LAST_STAGE) begin
                    state_next = ST_TP;
                end else begin
                    stage_next = stage_reg + 2'd1;
                    state_next = ST_LK;
                end
            end
            ST_TP: begin
                cmd.ld_t   = 1'b1;
                state_next = ST_DV;
            end
            ST_DV: begin
                cmd.mul_sel = lifrk_pkg::MUL_RECIP;
                state_next  = ST_QC;
            end
            ST_QC: begin
                cmd.ld_q   = 1'b1;
                state_next = ST_FN;
            end
            ST_FN: begin
                cmd.ld_vnew = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT: begin
                // hold until the output register can take the word
                if (out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Output word valid flag
    always_comb begin
        if (cmd.commit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            stage_reg     <= FIRST_STAGE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            stage_reg     <= stage_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/lifrk_dp.sv @@
`default_nettype none

module lifrk_dp (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire lifrk_pkg::dp_cmd_t              cmd,
    input  wire lifrk_pkg::cfg_t                 cfg,
    input  wire logic [lifrk_pkg::DATA_W-1:0]    s_tdata,
    output logic      [2*lifrk_pkg::DATA_W-1:0]  m_tdata,
    output logic      [0:0]                      m_tuser
);

    localparam int DW      = lifrk_pkg::DATA_W;
    localparam int OW      = lifrk_pkg::OPND_W;
    localparam int PW      = lifrk_pkg::PROD_W;
    localparam int FB      = lifrk_pkg::FRAC_BITS;
    localparam int PART_W  = PW - FB;
    localparam int SAT_W   = PW + 2;
    localparam int SUM_W   = DW + 4;
    localparam int Q_W     = DW + 1;
    localparam int VQ_W    = DW + 3;
    localparam int CW      = lifrk_pkg::CNT_W;
    localparam int RECIP_SHIFT = 30;

    localparam logic [DW-1:0]    RECIP3   = 32'h5555_5555;
    localparam logic [SUM_W-1:0] DIV_BIAS = 36'h1_8000_0000;
    localparam logic [VQ_W-1:0]  Q_BIAS   = 35'h0_8000_0000;

    function automatic logic signed [DW-1:0] sat32(input logic signed [SAT_W-1:0] x);
        logic [SAT_W-DW:0] hi;
        hi = x[SAT_W-1:DW-1];
        if (hi == '0 || hi == '1) begin
            return x[DW-1:0];
        end else if (x[SAT_W-1]) begin
            return {1'b1, {(DW-1){1'b0}}};
        end else begin
            return {1'b0, {(DW-1){1'b1}}};
        end
    endfunction

    // Configuration views with sign
    logic signed [DW-1:0] e_leak, e_syn, t_base, t_max;
    logic [lifrk_pkg::DECAY_W-1:0] decay_sat;

    assign e_leak    = cfg.leak_reversal;
    assign e_syn     = cfg.syn_reversal;
    assign t_base    = cfg.thresh_base;
    assign t_max     = cfg.thresh_max;
    assign decay_sat = (cfg.thresh_decay > lifrk_pkg::DECAY_ONE) ? lifrk_pkg::DECAY_ONE
                                                                 : cfg.thresh_decay;

    // Architectural state
    logic signed [DW-1:0] v_reg, v_next;
    logic signed [DW-1:0] thr_reg, thr_next;
    logic [CW-1:0]        cnt_reg, cnt_next;

    // Working registers
    logic signed [DW-1:0]     drive_reg, vs_reg, ch_reg, cf_reg, d_reg;
    logic signed [DW-1:0]     thr_dec_reg, vnew_reg;
    logic signed [PW-1:0]     prod_reg, prod_next;
    logic signed [PART_W-1:0] acc_reg;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic [DW-1:0]            t_reg;
    logic [3:0]               ulo_reg;
    logic [Q_W-1:0]           q_reg;
    logic                     out_fired_reg;
    logic [DW-1:0]            out_v_reg, out_thr_reg;

    // Shared multiplier operands
    logic signed [OW-1:0] mul_a, mul_b;
    logic signed [OW-1:0] vs_m_el, vs_m_es, base_m_thr;
    logic signed [DW-1:0] c_sel;

    assign vs_m_el    = {vs_reg[DW-1], vs_reg} - {e_leak[DW-1], e_leak};
    assign vs_m_es    = {vs_reg[DW-1], vs_reg} - {e_syn[DW-1], e_syn};
    assign base_m_thr = {t_base[DW-1], t_base} - {thr_reg[DW-1], thr_reg};
    assign c_sel      = cmd.syn_full ? cf_reg : ch_reg;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.mul_sel)
            lifrk_pkg::MUL_DRV_HALF: begin
                mul_a = {drive_reg[DW-1], drive_reg};
                mul_b = {2'b00, cfg.syn_gain_half};
            end
            lifrk_pkg::MUL_DRV_FULL: begin
                mul_a = {drive_reg[DW-1], drive_reg};
                mul_b = {2'b00, cfg.syn_gain_full};
            end
            lifrk_pkg::MUL_LEAK: begin
                mul_a = vs_m_el;
                mul_b = {2'b00, cfg.leak_gain};
            end
            lifrk_pkg::MUL_SYN: begin
                mul_a = vs_m_es;
                mul_b = {c_sel[DW-1], c_sel};
            end
            lifrk_pkg::MUL_THR: begin
                mul_a = base_m_thr;
                mul_b = {{(OW-lifrk_pkg::DECAY_W){1'b0}}, decay_sat};
            end
            lifrk_pkg::MUL_RECIP: begin
                mul_a = {1'b0, t_reg};
                mul_b = {1'b0, RECIP3};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // Product shifted down by the fraction bits (floor)
    logic signed [PART_W-1:0] prod_part;
    logic signed [DW-1:0]     c_val;

    assign prod_part = prod_reg[PW-1:FB];
    assign c_val     = sat32({{(SAT_W-PART_W){prod_part[PART_W-1]}}, prod_part});

    // Stage slope: negated sum of leak and synaptic terms, saturated
    logic signed [PART_W-1:0] syn_part;
    logic signed [PART_W+1:0] term_neg;
    logic signed [DW-1:0]     d_val;

    assign syn_part = cmd.syn_zero ? '0 : prod_part;
    assign term_neg = -({{2{acc_reg[PART_W-1]}}, acc_reg}
                        + {{2{syn_part[PART_W-1]}}, syn_part});
    assign d_val    = sat32({{(SAT_W-PART_W-2){term_neg[PART_W+1]}}, term_neg});

    // Relaxed threshold: the step stays between thr and base, so it fits
    logic signed [DW-1:0] thr_dec_val;
    assign thr_dec_val = thr_reg + prod_reg[lifrk_pkg::DECAY_SHIFT+DW-1:lifrk_pkg::DECAY_SHIFT];

    // Next stage voltage
    logic signed [DW-1:0] vs_inc, vs_val;
    logic signed [DW:0]   vs_sum;

    assign vs_inc = cmd.vs_full ? d_reg : {d_reg[DW-1], d_reg[DW-1:1]};
    assign vs_sum = {v_reg[DW-1], v_reg} + {vs_inc[DW-1], vs_inc};
    assign vs_val = sat32({{(SAT_W-DW-1){vs_sum[DW]}}, vs_sum});

    // Weighted slope sum d1 + 2 d2 + 2 d3 + d4
    logic signed [SUM_W-1:0] d_ext;
    assign d_ext = {{(SUM_W-DW){d_reg[DW-1]}}, d_reg};

    always_comb begin
        unique case (cmd.sum_op)
            lifrk_pkg::SUM_HOLD: sum_next = sum_reg;
            lifrk_pkg::SUM_LOAD: sum_next = d_ext;
            lifrk_pkg::SUM_ADD2: sum_next = sum_reg + {d_ext[SUM_W-2:0], 1'b0};
            lifrk_pkg::SUM_ADD1: sum_next = sum_reg + d_ext;
        endcase
    end

    // Floor divide by six: halve, bias positive, then divide by three
    // through a reciprocal estimate and a small remainder correction
    logic [SUM_W-1:0] u_val;
    logic [Q_W-1:0]   est;
    logic [3:0]       est3, rem;
    logic [1:0]       corr;

    assign u_val = {sum_reg[SUM_W-1], sum_reg[SUM_W-1:1]} + DIV_BIAS;
    assign est   = prod_reg[RECIP_SHIFT+Q_W-1:RECIP_SHIFT];
    assign est3  = {est[2:0], 1'b0} + est[3:0];
    assign rem   = ulo_reg - est3;

    always_comb begin
        priority if (rem >= 4'd9) begin
            corr = 2'd3;
        end else if (rem >= 4'd6) begin
            corr = 2'd2;
        end else if (rem >= 4'd3) begin
            corr = 2'd1;
        end else begin
            corr = 2'd0;
        end
    end

    // New voltage: saturate, then clamp at the ceiling
    logic signed [VQ_W-1:0] vq_sum;
    logic signed [DW-1:0]   vq_sat, vnew_val;

    assign vq_sum   = {{(VQ_W-DW){v_reg[DW-1]}}, v_reg}
                      + {{(VQ_W-Q_W){1'b0}}, q_reg} - Q_BIAS;
    assign vq_sat   = sat32({{(SAT_W-VQ_W){vq_sum[VQ_W-1]}}, vq_sum});
    assign vnew_val = (vq_sat > t_max) ? t_max : vq_sat;

    // Spike decision and state commit
    logic          fire;
    logic [CW-1:0] cnt_base;

    assign fire     = (cnt_reg > lifrk_pkg::REFRACT_TICKS) && (vnew_reg > thr_dec_reg);
    assign cnt_base = fire ? '0 : cnt_reg;

    always_comb begin
        v_next   = v_reg;
        thr_next = thr_reg;
        cnt_next = cnt_reg;
        if (cmd.commit) begin
            v_next   = vnew_reg;
            thr_next = fire ? t_max : thr_dec_reg;
            cnt_next = (cnt_base != {CW{1'b1}}) ? cnt_base + CW'(1) : cnt_base;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg   <= '0;
            thr_reg <= '0;
            cnt_reg <= '0;
        end else begin
            v_reg   <= v_next;
            thr_reg <= thr_next;
            cnt_reg <= cnt_next;
        end
    end

    // Working and output payload registers
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        sum_reg  <= sum_next;
        if (cmd.ld_in) begin
            drive_reg <= s_tdata;
            vs_reg    <= v_reg;
        end
        if (cmd.ld_ch) begin
            ch_reg <= c_val;
        end
        if (cmd.ld_cf) begin
            cf_reg <= c_val;
        end
        if (cmd.ld_acc) begin
            acc_reg <= prod_part;
        end
        if (cmd.ld_d) begin
            d_reg <= d_val;
        end
        if (cmd.ld_thr) begin
            thr_dec_reg <= thr_dec_val;
        end
        if (cmd.ld_vs) begin
            vs_reg <= vs_val;
        end
        if (cmd.ld_t) begin
            t_reg   <= u_val[DW+1:2];
            ulo_reg <= u_val[3:0];
        end
        if (cmd.ld_q) begin
            q_reg <= est + {{(Q_W-2){1'b0}}, corr};
        end
        if (cmd.ld_vnew) begin
            vnew_reg <= vnew_val;
        end
        if (cmd.commit) begin
            out_fired_reg <= fire;
            out_v_reg     <= vnew_reg;
            out_thr_reg   <= fire ? t_max : thr_dec_reg;
        end
    end

    assign m_tdata = {out_thr_reg, out_v_reg};
    assign m_tuser = out_fired_reg;

endmodule

`default_nettype wire

@@ sv/lif_neuron_rk4_step_unit.sv @@
// Leaky integrate-and-fire neuron, one RK4 time step per input word.
// Input stream (s_*): s_tdata carries the summed synaptic drive, signed Q16.16.
// Output stream (m_*): one word per input; m_tuser[0] is the spike flag,
// m_tdata holds the clamped membrane voltage and the updated threshold.
// Configuration goes through the APB port (8 registers at 4-byte steps);
// program it while no step is in flight.
// The unit takes no new input word until the current step is done. Each step
// runs 11 products through a single shared 33x33 multiplier, sequenced by the
// four dependent RK4 stages and the final divide by six.
// Reset: all registers read zero; voltage, threshold and spike counter start
// at zero and later register writes do not touch them.
// Back-pressure: the result sits in an output register, so the next input
// word is taken while it waits; a second result holds the unit until the
// receiver takes the first.
`default_nettype none

module lif_neuron_rk4_step_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // input stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [lifrk_pkg::DATA_W-1:0]    s_tdata,   // [31:0] synaptic_drive
    // result stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [2*lifrk_pkg::DATA_W-1:0]  m_tdata,   // [31:0] membrane_voltage,
                                                            // [63:32] firing_threshold
    output logic      [0:0]                      m_tuser,   // [0] fired
    // configuration
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [lifrk_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [lifrk_pkg::APB_W-1:0]     pwdata,
    output logic      [lifrk_pkg::APB_W-1:0]     prdata,
    output logic                                 pready
);

    lifrk_pkg::cfg_t    cfg;
    lifrk_pkg::dp_cmd_t cmd;

    lifrk_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lifrk_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    lifrk_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .cfg     (cfg),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule

`default_nettype wire
